FILE: hw/rtl/aatl_pkg.sv
// Package for the anti-aliased thick line rasterizer.
// Holds sizes, fixed-point widths, command and register codes, and shared types.
// No dependencies.
package aatl_pkg;

    // Frame store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = XW + YW;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    // Field and register widths
    localparam int COORD_W   = 13;
    localparam int PW        = COORD_W + 2;
    localparam int VIEW_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 8;
    localparam int S_DATA_W  = 104;
    localparam int M_DATA_W  = 24;

    // Fixed-point datapath widths
    localparam int SQ_W   = 2 * COORD_W + 1;
    localparam int RAD_W  = ((SQ_W + 2 * FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int NUM_W  = COORD_W + 8 + 2 * FRAC_BITS + 1;
    localparam int D_W    = FRAC_BITS + 9;
    localparam int N_W    = 10;
    localparam int HALF_W = 16 + FRAC_BITS - 1;
    localparam int INT_W  = HALF_W + 5;
    localparam int PROD_W = INT_W + 8;
    localparam int CNT_W  = $clog2(NUM_W);

    // Full intensity (255 in fixed point) and the saturation point of a scaled channel
    localparam int FULL = 255 * (2 ** FRAC_BITS);
    localparam logic signed [INT_W-1:0] FULL_S = INT_W'(FULL);
    localparam logic [PROD_W-1:0] SAT_P = PROD_W'(256 * FULL);

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    // One pixel of the frame store
    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    // Sequencer states
    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_CLEAR   = 20'h00002,
        ST_RD      = 20'h00004,
        ST_RD_DATA = 20'h00008,
        ST_DONE    = 20'h00010,
        ST_SWAP    = 20'h00020,
        ST_CHK     = 20'h00040,
        ST_PT      = 20'h00080,
        ST_SQRT    = 20'h00100,
        ST_PREP    = 20'h00200,
        ST_DVX     = 20'h00400,
        ST_DVY     = 20'h00800,
        ST_PREPN   = 20'h01000,
        ST_DVN     = 20'h02000,
        ST_INIT    = 20'h04000,
        ST_ROW     = 20'h08000,
        ST_ERD     = 20'h10000,
        ST_EWR     = 20'h20000,
        ST_CORE    = 20'h40000,
        ST_STEP    = 20'h80000
    } state_t;

endpackage

FILE: hw/rtl/antialiased_thick_line_raster.sv
// Top level of the anti-aliased thick line rasterizer with its RGB frame store.
// Depends on aatl_pkg.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: cmd; tdata: line, color and read fields
// m_*       out        m_tvalid/m_tready  tuser: status; tdata: pixel_red/green/blue
// cfg_*     in         cfg_we             cfg_index selects frame_width or frame_height
//
// One item is worked at a time through a single-port frame store of 65536 pixels.
// A read checks the bounds and fetches the pixel, a clear blanks every pixel, and a draw
// runs checks, root and divides, then walks each row or column with border and core pixels.
// After reset a clearing pass over the whole store runs before the first item is taken.
// The result waits in an output register; the next item is taken while it waits.
module antialiased_thick_line_raster (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // x_start[12:0] y_start[25:13] x_end[38:26] y_end[51:39] line_width[59:52]
    // red[67:60] green[75:68] blue[83:76] read_x[91:84] read_y[99:92], zero fill
    input  logic [aatl_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [aatl_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_red[7:0] pixel_green[15:8] pixel_blue[23:16]
    output logic [aatl_pkg::M_DATA_W-1:0] m_tdata,
    // status[0]
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [aatl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aatl_pkg::VIEW_W-1:0]   cfg_data
);
    import aatl_pkg::*;

    // Control registers
    state_t              state_reg, state_next;
    logic [VIEW_W-1:0]   fw_reg, fw_next, fh_reg, fh_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_cmd_reg, clr_cmd_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic signed [COORD_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [COORD_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic [7:0]          lw_reg, lw_next, rx_reg, rx_next, ry_reg, ry_next;
    rgb_t                pen_reg, pen_next;
    logic                res_status_reg, res_status_next;
    rgb_t                res_pix_reg, res_pix_next;
    logic                out_status_reg, out_status_next;
    rgb_t                out_pix_reg, out_pix_next;
    logic [COORD_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic                sy_reg, sy_next, steep_reg, steep_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W+1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [ROOT_W:0]     drem_reg, drem_next;
    logic [ROOT_W-1:0]   div_reg, div_next;
    logic [D_W-1:0]      dxs_reg, dxs_next, dys_reg, dys_next;
    logic [D_W-1:0]      dmaj_reg, dmaj_next, dmin_reg, dmin_next;
    logic [HALF_W-1:0]   half_reg, half_next;
    logic [N_W-1:0]      n_reg, n_next;
    logic signed [PW-1:0] maj_reg, maj_next, maj_end_reg, maj_end_next;
    logic signed [PW-1:0] base_reg, base_next, c_reg, c_next;
    logic signed [INT_W-1:0] err_reg, err_next, t_reg, t_next, inten_reg, inten_next;
    logic                majneg_reg, majneg_next, minneg_reg, minneg_next;
    logic [VIEW_W-1:0]   lim_reg, lim_next;
    logic                edge2_reg, edge2_next;
    logic                pos_reg, pos_next;
    logic [PROD_W-1:0]   prod_r_reg, prod_r_next, prod_g_reg, prod_g_next;
    logic [PROD_W-1:0]   prod_b_reg, prod_b_next;

    // Frame store port
    rgb_t                mem [DEPTH];
    rgb_t                rdata_reg;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    rgb_t                mem_wdata;

    // Combinational helpers
    logic [VIEW_W-1:0]   vw, vh;
    logic signed [PW-1:0] vw_s, vh_s, lim_s;
    logic signed [PW-1:0] x0e, y0e, x1e, y1e, dx_w, dy_w, ne;
    logic signed [PW-1:0] minstep, majstep, cur_c, px, py;
    logic                sy, out_x, out_y, pix_in, brk;
    logic [2*COORD_W-1:0] dxsq, dysq;
    logic [SQ_W-1:0]     sq;
    logic [ROOT_W+1:0]   rem_sh, trial;
    logic                sq_ge;
    logic [ROOT_W:0]     drem_sh;
    logic                dv_ge;
    logic [NUM_W-1:0]    q_fin, mulx, muly;
    logic [HALF_W-1:0]   half_c;
    logic [7:0]          wm1;
    logic [N_W+D_W-1:0]  nd_prod;
    logic signed [INT_W-1:0] tsum, errs;
    logic signed [INT_W:0] diff;
    logic [INT_W-1:0]    diff_u;
    logic                swap;

    // Scale a channel by (FULL - intensity) / FULL, saturated to 0..255.
    function automatic logic [CHAN_W-1:0] scale_chan(logic [PROD_W-1:0] prod, logic pos);
        logic [15:0] x;
        logic [24:0] m;
        logic [7:0]  q0;
        logic [16:0] r;
        x  = prod[FRAC_BITS+15:FRAC_BITS];
        m  = 25'(x) * 25'd257;
        q0 = m[23:16];
        r  = 17'(x) - 17'(q0) * 17'd255;
        if (r >= 17'd255)
        begin
            q0 = q0 + 8'd1;
        end
        if (!pos)
        begin
            return '0;
        end
        else if (prod >= SAT_P)
        begin
            return 8'hFF;
        end
        return q0;
    endfunction

    // Viewport clamped to the store size
    assign vw    = (fw_reg > VIEW_W'(MAX_WIDTH)) ? VIEW_W'(MAX_WIDTH) : fw_reg;
    assign vh    = (fh_reg > VIEW_W'(MAX_HEIGHT)) ? VIEW_W'(MAX_HEIGHT) : fh_reg;
    assign vw_s  = $signed({{(PW-VIEW_W){1'b0}}, vw});
    assign vh_s  = $signed({{(PW-VIEW_W){1'b0}}, vh});
    assign lim_s = $signed({{(PW-VIEW_W){1'b0}}, lim_reg});

    // End points and line extent
    assign x0e   = PW'(x0_reg);
    assign y0e   = PW'(y0_reg);
    assign x1e   = PW'(x1_reg);
    assign y1e   = PW'(y1_reg);
    assign sy    = y0_reg < y1_reg;
    assign out_x = (x0e > vw_s) || (x1_reg < 0);
    assign out_y = sy ? ((y0e > vh_s) || (y1_reg < 0)) : ((y1e > vh_s) || (y0_reg < 0));
    assign dx_w  = x1e - x0e;
    assign dy_w  = sy ? (y1e - y0e) : (y0e - y1e);
    assign dxsq  = dx_w[COORD_W-1:0] * dx_w[COORD_W-1:0];
    assign dysq  = dy_w[COORD_W-1:0] * dy_w[COORD_W-1:0];
    assign sq    = SQ_W'(dxsq) + SQ_W'(dysq);
    assign swap  = x0_reg > x1_reg;

    // Square root step: two radicand bits per cycle
    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    // Restoring divide step: one quotient bit per cycle
    assign drem_sh = {drem_reg[ROOT_W-1:0], num_reg[NUM_W-1]};
    assign dv_ge   = drem_sh >= {1'b0, div_reg};
    assign q_fin   = {num_reg[NUM_W-2:0], dv_ge};

    // Numerators of the step divides and the half width
    assign mulx   = NUM_W'(dx_reg) * NUM_W'(255);
    assign muly   = NUM_W'(dy_reg) * NUM_W'(255);
    assign wm1    = (lw_reg == 8'd0) ? 8'd0 : (lw_reg - 8'd1);
    assign half_c = (HALF_W'(wm1) * HALF_W'(255)) << (FRAC_BITS - 1);
    assign nd_prod = n_reg * dmaj_reg;
    assign ne     = $signed({{(PW-N_W){1'b0}}, n_reg});

    // Walk position
    assign minstep = minneg_reg ? -PW'(1) : PW'(1);
    assign majstep = majneg_reg ? -PW'(1) : PW'(1);
    assign cur_c   = (state_reg == ST_CORE) ? (c_reg + minstep) : c_reg;
    assign px      = steep_reg ? cur_c : maj_reg;
    assign py      = steep_reg ? maj_reg : cur_c;
    assign pix_in  = (px >= 0) && (py >= 0) && (px < vw_s) && (py < vh_s);
    assign brk     = majneg_reg ? (maj_reg < 0) : (maj_reg > lim_s);
    assign tsum    = t_reg + $signed(INT_W'(dmaj_reg));
    assign errs    = err_reg + $signed(INT_W'(dmin_reg));
    assign diff    = $signed((INT_W+1)'(FULL_S)) - $signed((INT_W+1)'(inten_reg));
    assign diff_u  = diff[INT_W-1:0];

    // Frame store address and write data
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = pen_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_addr  = clr_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_RD, ST_RD_DATA:
            begin
                mem_addr = {ry_reg[YW-1:0], rx_reg[XW-1:0]};
            end
            ST_PT:
            begin
                mem_addr = {py[YW-1:0], px[XW-1:0]};
                mem_we   = pix_in;
            end
            ST_EWR:
            begin
                mem_addr  = {py[YW-1:0], px[XW-1:0]};
                mem_we    = pix_in && (rdata_reg == '0);
                mem_wdata = '{r: scale_chan(prod_r_reg, pos_reg),
                              g: scale_chan(prod_g_reg, pos_reg),
                              b: scale_chan(prod_b_reg, pos_reg)};
            end
            ST_CORE:
            begin
                mem_addr = {py[YW-1:0], px[XW-1:0]};
                mem_we   = pix_in && (tsum < FULL_S);
            end
            default:
            begin
                mem_addr = {py[YW-1:0], px[XW-1:0]};
            end
        endcase
    end

    // Frame store: one synchronous port, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        fw_next         = fw_reg;
        fh_next         = fh_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_cmd_next    = clr_cmd_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_pix_next    = out_pix_reg;
        x0_next = x0_reg; y0_next = y0_reg; x1_next = x1_reg; y1_next = y1_reg;
        lw_next = lw_reg; rx_next = rx_reg; ry_next = ry_reg; pen_next = pen_reg;
        res_status_next = res_status_reg;
        res_pix_next    = res_pix_reg;
        dx_next = dx_reg; dy_next = dy_reg; sy_next = sy_reg; steep_next = steep_reg;
        rad_next = rad_reg; rem_next = rem_reg; root_next = root_reg; cnt_next = cnt_reg;
        num_next = num_reg; drem_next = drem_reg; div_next = div_reg;
        dxs_next = dxs_reg; dys_next = dys_reg; dmaj_next = dmaj_reg; dmin_next = dmin_reg;
        half_next = half_reg; n_next = n_reg;
        maj_next = maj_reg; maj_end_next = maj_end_reg; base_next = base_reg; c_next = c_reg;
        err_next = err_reg; t_next = t_reg; inten_next = inten_reg;
        majneg_next = majneg_reg; minneg_next = minneg_reg; lim_next = lim_reg;
        edge2_next = edge2_reg; pos_next = pos_reg;
        prod_r_next = prod_r_reg; prod_g_next = prod_g_reg; prod_b_next = prod_b_reg;
        s_tready = 1'b0;

        // Configuration writes
        if (cfg_we && (cfg_index == CFG_WIDTH))
        begin
            fw_next = cfg_data;
        end
        if (cfg_we && (cfg_index == CFG_HEIGHT))
        begin
            fh_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    x0_next  = $signed(s_tdata[12:0]);
                    y0_next  = $signed(s_tdata[25:13]);
                    x1_next  = $signed(s_tdata[38:26]);
                    y1_next  = $signed(s_tdata[51:39]);
                    lw_next  = s_tdata[59:52];
                    pen_next = '{r: s_tdata[67:60], g: s_tdata[75:68], b: s_tdata[83:76]};
                    rx_next  = s_tdata[91:84];
                    ry_next  = s_tdata[99:92];
                    res_status_next = 1'b0;
                    res_pix_next    = '0;
                    case (cmd_t'(s_tuser))
                        CMD_DRAW:  state_next = ST_SWAP;
                        CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        CMD_READ:  state_next = ST_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_RD:
            begin
                if ((VIEW_W'(rx_reg) >= vw) || (VIEW_W'(ry_reg) >= vh))
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    state_next = ST_RD_DATA;
                end
            end
            ST_RD_DATA:
            begin
                res_pix_next = rdata_reg;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pix_next    = res_pix_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_SWAP:
            begin
                if (swap)
                begin
                    x0_next = x1_reg; y0_next = y1_reg;
                    x1_next = x0_reg; y1_next = y0_reg;
                end
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                sy_next = sy;
                dx_next = dx_w[COORD_W-1:0];
                dy_next = dy_w[COORD_W-1:0];
                if (out_x || out_y)
                begin
                    state_next = ST_DONE;
                end
                else if ((dx_w == 0) && (dy_w == 0))
                begin
                    // Zero-length line: the start pixel alone, in full color.
                    steep_next = 1'b0;
                    maj_next   = x0e;
                    c_next     = y0e;
                    state_next = ST_PT;
                end
                else
                begin
                    rad_next   = RAD_W'(sq) << (2 * FRAC_BITS);
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_PT:
            begin
                state_next = ST_DONE;
            end
            ST_SQRT:
            begin
                rem_next  = sq_ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                rad_next  = rad_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                num_next   = (mulx << (2 * FRAC_BITS)) + NUM_W'(root_reg >> 1);
                div_next   = root_reg;
                drem_next  = '0;
                cnt_next   = '0;
                state_next = ST_DVX;
            end
            ST_DVX, ST_DVY, ST_DVN:
            begin
                drem_next = dv_ge ? (drem_sh - {1'b0, div_reg}) : drem_sh;
                num_next  = q_fin;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    cnt_next  = '0;
                    drem_next = '0;
                    if (state_reg == ST_DVX)
                    begin
                        dxs_next   = q_fin[D_W-1:0];
                        num_next   = (muly << (2 * FRAC_BITS)) + NUM_W'(root_reg >> 1);
                        state_next = ST_DVY;
                    end
                    else if (state_reg == ST_DVY)
                    begin
                        dys_next   = q_fin[D_W-1:0];
                        state_next = ST_PREPN;
                    end
                    else
                    begin
                        n_next     = q_fin[N_W-1:0];
                        state_next = ST_INIT;
                    end
                end
            end
            ST_PREPN:
            begin
                // Steep lines walk rows and step by DY; flat ones walk columns.
                steep_next = dxs_reg < dys_reg;
                dmaj_next  = (dxs_reg < dys_reg) ? dys_reg : dxs_reg;
                dmin_next  = (dxs_reg < dys_reg) ? dxs_reg : dys_reg;
                half_next  = half_c;
                num_next   = NUM_W'(root_reg) + NUM_W'(half_c)
                           + NUM_W'(((dxs_reg < dys_reg) ? dys_reg : dxs_reg) >> 1);
                div_next   = ROOT_W'((dxs_reg < dys_reg) ? dys_reg : dxs_reg);
                drem_next  = '0;
                cnt_next   = '0;
                state_next = ST_DVN;
            end
            ST_INIT:
            begin
                err_next = $signed(INT_W'(nd_prod)) - $signed(INT_W'(half_reg));
                if (steep_reg)
                begin
                    base_next    = x0e - ne;
                    maj_next     = y0e;
                    maj_end_next = y1e;
                    majneg_next  = !sy_reg;
                    minneg_next  = 1'b0;
                    lim_next     = vh;
                end
                else
                begin
                    base_next    = sy_reg ? (y0e - ne) : (y0e + ne);
                    maj_next     = x0e;
                    maj_end_next = x1e;
                    majneg_next  = 1'b0;
                    minneg_next  = !sy_reg;
                    lim_next     = vw;
                end
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                if (brk)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    c_next     = base_reg;
                    inten_next = err_reg;
                    edge2_next = 1'b0;
                    state_next = ST_ERD;
                end
            end
            ST_ERD:
            begin
                // Border color products while the pixel is fetched.
                pos_next    = diff > 0;
                prod_r_next = PROD_W'(pen_reg.r) * PROD_W'(diff_u);
                prod_g_next = PROD_W'(pen_reg.g) * PROD_W'(diff_u);
                prod_b_next = PROD_W'(pen_reg.b) * PROD_W'(diff_u);
                state_next  = ST_EWR;
            end
            ST_EWR:
            begin
                if (!edge2_reg)
                begin
                    t_next = $signed(INT_W'(dmaj_reg)) - err_reg - $signed(INT_W'(half_reg));
                    state_next = ST_CORE;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_CORE:
            begin
                c_next = c_reg + minstep;
                if (tsum < FULL_S)
                begin
                    t_next = tsum;
                end
                else
                begin
                    inten_next = t_reg;
                    edge2_next = 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_STEP:
            begin
                if (maj_reg == maj_end_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    maj_next = maj_reg + majstep;
                    if (errs > FULL_S)
                    begin
                        err_next  = errs - $signed(INT_W'(dmaj_reg));
                        base_next = base_reg + minstep;
                    end
                    else
                    begin
                        err_next = errs;
                    end
                    state_next = ST_ROW;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset; a clearing pass follows reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            fw_reg        <= VIEW_W'(256);
            fh_reg        <= VIEW_W'(256);
            clr_cnt_reg   <= '0;
            clr_cmd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_cmd_reg   <= clr_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_pix_reg    <= out_pix_next;
        x0_reg <= x0_next; y0_reg <= y0_next; x1_reg <= x1_next; y1_reg <= y1_next;
        lw_reg <= lw_next; rx_reg <= rx_next; ry_reg <= ry_next; pen_reg <= pen_next;
        res_status_reg <= res_status_next;
        res_pix_reg    <= res_pix_next;
        dx_reg <= dx_next; dy_reg <= dy_next; sy_reg <= sy_next; steep_reg <= steep_next;
        rad_reg <= rad_next; rem_reg <= rem_next; root_reg <= root_next; cnt_reg <= cnt_next;
        num_reg <= num_next; drem_reg <= drem_next; div_reg <= div_next;
        dxs_reg <= dxs_next; dys_reg <= dys_next; dmaj_reg <= dmaj_next; dmin_reg <= dmin_next;
        half_reg <= half_next; n_reg <= n_next;
        maj_reg <= maj_next; maj_end_reg <= maj_end_next; base_reg <= base_next;
        c_reg <= c_next;
        err_reg <= err_next; t_reg <= t_next; inten_reg <= inten_next;
        majneg_reg <= majneg_next; minneg_reg <= minneg_next; lim_reg <= lim_next;
        edge2_reg <= edge2_next; pos_reg <= pos_next;
        prod_r_reg <= prod_r_next; prod_g_reg <= prod_g_next; prod_b_reg <= prod_b_next;
    end

    // Output port
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_pix_reg.b, out_pix_reg.g, out_pix_reg.r};

    // The store is never written while the block waits for an item.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("frame store written while idle");

    // A result only appears after the sequencer has finished an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    // The offset divide never runs with a zero step.
    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DVN) && $past(state_reg == ST_PREPN)) |-> (div_reg != '0))
        else $error("offset divide by zero step");

    // A border write always follows its own pixel fetch.
    a_edge_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EWR) |-> $past(state_reg == ST_ERD))
        else $error("border write without fetch");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the anti-aliased thick line rasterizer.
// Streams draw, clear, read and idle commands while predicting each result from
// a local frame store copy. Depends on aatl_pkg and antialiased_thick_line_raster.
`timescale 1ns / 1ps

module testbench;
    import aatl_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [12:0] xs;
        logic [12:0] ys;
        logic [12:0] xe;
        logic [12:0] ye;
        logic [7:0]  lw;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  rx;
        logic [7:0]  ry;
    } raster_cmd_t;

    typedef struct {
        logic       status;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_result_t;

    localparam longint FONE_L = 256;
    localparam longint FULL_L = 255 * 256;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VIEW_W-1:0] cfg_data = '0;

    raster_cmd_t   pending_cmds[$];
    pixel_result_t expected_pixels[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Shadow of the frame store and viewport registers.
    logic [23:0] shadow_store [0:65535];
    int unsigned shadow_width = 256;
    int unsigned shadow_height = 256;
    int view_w;
    int view_h;
    logic [7:0] pen_r, pen_g, pen_b;

    antialiased_thick_line_raster dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic bit in_view(int x, int y);
        return x >= 0 && y >= 0 && x < view_w && y < view_h;
    endfunction

    function automatic void plot_core(int x, int y);
        if (in_view(x, y))
            shadow_store[y * MAX_WIDTH + x] = {pen_r, pen_g, pen_b};
    endfunction

    function automatic logic [7:0] fade_channel(logic [7:0] c, longint inten);
        longint num;
        longint q;
        num = longint'(c) * (FULL_L - inten);
        if (num <= 0)
            return 8'd0;
        q = num / FULL_L;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Border pixels only land on pixels that are still black.
    function automatic void plot_border(int x, int y, longint inten);
        int idx;
        if (!in_view(x, y))
            return;
        idx = y * MAX_WIDTH + x;
        if (shadow_store[idx] != 24'd0)
            return;
        shadow_store[idx] = {fade_channel(pen_r, inten), fade_channel(pen_g, inten),
                             fade_channel(pen_b, inten)};
    endfunction

    function automatic void rasterize(int x0, int y0, int x1, int y1, int w);
        int sy, dx, dy, n, c, tmp;
        longint len, stepx, stepy, half, err, t;
        if (w < 1)
            w = 1;
        // End points are ordered left to right.
        if (x0 > x1)
        begin
            tmp = x0; x0 = x1; x1 = tmp;
            tmp = y0; y0 = y1; y1 = tmp;
        end
        if (x0 > view_w || x1 < 0)
            return;
        sy = (y0 < y1) ? 1 : -1;
        if (sy == 1 && (y0 > view_h || y1 < 0))
            return;
        if (sy == -1 && (y1 > view_h || y0 < 0))
            return;
        dx = x1 - x0;
        dy = (y0 < y1) ? y1 - y0 : y0 - y1;
        if (dx == 0 && dy == 0)
        begin
            plot_core(x0, y0);
            return;
        end
        len = int_sqrt((longint'(dx) * dx + longint'(dy) * dy) << 16);
        stepx = (longint'(dx) * 255 * FONE_L * FONE_L + len / 2) / len;
        stepy = (longint'(dy) * 255 * FONE_L * FONE_L + len / 2) / len;
        half = 255 * longint'(w - 1) * FONE_L / 2;
        if (stepx < stepy)
        begin
            // Steep: one row per step.
            n = int'((len + half + stepy / 2) / stepy);
            err = longint'(n) * stepy - half;
            x0 = x0 - n;
            forever
            begin
                if ((sy == 1 && y0 > view_h) || (sy == -1 && y0 < 0))
                    break;
                c = x0;
                plot_border(c, y0, err);
                for (t = stepy - err - half; t + stepy < FULL_L; t += stepy)
                begin
                    c++;
                    plot_core(c, y0);
                end
                plot_border(c + 1, y0, t);
                if (y0 == y1)
                    break;
                err += stepx;
                if (err > FULL_L)
                begin
                    err -= stepy;
                    x0++;
                end
                y0 += sy;
            end
        end
        else
        begin
            // Flat: one column per step.
            n = int'((len + half + stepx / 2) / stepx);
            err = longint'(n) * stepx - half;
            y0 = y0 - n * sy;
            forever
            begin
                if (x0 > view_w)
                    break;
                c = y0;
                plot_border(x0, c, err);
                for (t = stepx - err - half; t + stepx < FULL_L; t += stepx)
                begin
                    c += sy;
                    plot_core(x0, c);
                end
                plot_border(x0, c + sy, t);
                if (x0 == x1)
                    break;
                err += stepy;
                if (err > FULL_L)
                begin
                    err -= stepx;
                    y0 += sy;
                end
                x0++;
            end
        end
    endfunction

    function automatic pixel_result_t apply_command(raster_cmd_t it);
        pixel_result_t res;
        logic [23:0] px;
        res = '{1'b0, 8'd0, 8'd0, 8'd0};
        view_w = (shadow_width > MAX_WIDTH) ? MAX_WIDTH : int'(shadow_width);
        view_h = (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(shadow_height);
        case (it.cmd)
            CMD_DRAW:
            begin
                pen_r = it.r;
                pen_g = it.g;
                pen_b = it.b;
                rasterize($signed(it.xs), $signed(it.ys), $signed(it.xe), $signed(it.ye),
                          int'(it.lw));
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    shadow_store[i] = 24'd0;
            end
            CMD_READ:
            begin
                if (int'(it.rx) >= view_w || int'(it.ry) >= view_h)
                    res.status = 1'b1;
                else
                begin
                    px = shadow_store[int'(it.ry) * MAX_WIDTH + int'(it.rx)];
                    res.r = px[23:16];
                    res.g = px[15:8];
                    res.b = px[7:0];
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic raster_cmd_t make_cmd(cmd_t cmd, int xs, int ys, int xe, int ye,
                                             int lw, int r, int g, int b, int rx, int ry);
        raster_cmd_t it;
        it.cmd = cmd;
        it.xs = xs[12:0]; it.ys = ys[12:0]; it.xe = xe[12:0]; it.ye = ye[12:0];
        it.lw = lw[7:0]; it.r = r[7:0]; it.g = g[7:0]; it.b = b[7:0];
        it.rx = rx[7:0]; it.ry = ry[7:0];
        return it;
    endfunction

    function automatic int near_coord(int span);
        return $urandom_range(span + 32) - 16;
    endfunction

    // Random command mix: mostly short draws and reads with random content.
    function automatic raster_cmd_t random_cmd();
        int sel, span, lw, xa, xb;
        raster_cmd_t it;
        sel = $urandom_range(99);
        span = (shadow_width > 256) ? 256 : int'(shadow_width);
        lw = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        it = make_cmd(CMD_READ, 0, 0, 0, 0, lw, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255), $urandom_range(255));
        if (sel < 45)
        begin
            it.cmd = CMD_DRAW;
            xa = near_coord(span);
            it.xs = xa[12:0];
            it.xe = 13'(xa + int'($urandom_range(60)) - 30);
            it.ys = 13'(near_coord(span));
            it.ye = 13'($signed(it.ys) + int'($urandom_range(60)) - 30);
        end
        else if (sel < 50)
        begin
            // Far coordinates kept on one side so the line is rejected quickly.
            it.cmd = CMD_DRAW;
            xa = $urandom_range(4095);
            xb = $urandom_range(4095);
            if ($urandom_range(1))
            begin
                it.xs = 13'(-1 - xa);
                it.xe = 13'(-1 - xb);
            end
            else
            begin
                it.xs = 13'(xa | 2048);
                it.xe = 13'(xb | 2048);
            end
            it.ys = 13'($urandom);
            it.ye = 13'($urandom);
        end
        else if (sel < 95)
        begin
            if ($urandom_range(4) != 0)
            begin
                it.rx = 8'($urandom_range(span + 3 > 255 ? 255 : span + 3));
            end
        end
        else
            it.cmd = CMD_NOP;
        return it;
    endfunction

    // Driver: one item in flight on the slave side, idle gaps by percentage.
    always @(posedge clk)
    begin
        raster_cmd_t it;
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.cmd;
                s_tdata <= {4'd0, it.ry, it.rx, it.b, it.g, it.r, it.lw,
                            it.ye, it.xe, it.ys, it.xs};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Prediction of each accepted item.
    always @(posedge clk)
    begin
        raster_cmd_t it;
        if (s_tvalid && s_tready)
        begin
            it.cmd = cmd_t'(s_tuser);
            {it.ry, it.rx, it.b, it.g, it.r, it.lw, it.ye, it.xe, it.ys, it.xs} = s_tdata[99:0];
            expected_pixels.push_back(apply_command(it));
        end
    end

    // Receiver backpressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result status=%0d pixel=%h", m_tuser, m_tdata);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tuser !== want.status || m_tdata[7:0] !== want.r ||
                    m_tdata[15:8] !== want.g || m_tdata[23:16] !== want.b)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected status=%0d rgb=%h %h %h, got status=%0d rgb=%h %h %h",
                                 want.status, want.r, want.g, want.b,
                                 m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_pixels.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[VIEW_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            shadow_width = value;
        else
            shadow_height = value;
    endtask

    task automatic run_phase(int w, int h, int idle, int stall, int count, bit pause_midway);
        wait_drained();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            pending_cmds.push_back(random_cmd());
            if (pause_midway && i == count / 2)
                wait_drained();
        end
    endtask

    // Stimulus sequence.
    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            shadow_store[i] = 24'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every command and the named corner cases.
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 255, 255));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 10, 10, 10, 10, 0, 255, 255, 255, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 10, 10));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 20, 30, 60, 40, 3, 200, 100, 50, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 40, 35));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 100, 10, 110, 60, 5, 255, 0, 128, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 150, 80, 140, 20, 2, 1, 2, 3, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 90, 200, 30, 190, 4, 0, 255, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 60, 195));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 200, 200, 204, 203, 255, 255, 255, 255, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 202, 201));
        pending_cmds.push_back(make_cmd(CMD_DRAW, -4096, 5, 4095, 9, 1, 9, 9, 9, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 5, -4096, 7, 4095, 1, 7, 7, 7, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, -4096, -4096, -100, -50, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 300, 10, 4095, 20, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 10, 300, 20, 4095, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_DRAW, 250, 240, 270, 262, 3, 77, 88, 99, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 255, 250));
        pending_cmds.push_back(make_cmd(CMD_NOP, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 10, 10));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        run_phase(256, 256, 0, 0, 120, 1'b0);
        run_phase(511, 511, 60, 0, 110, 1'b0);
        run_phase(100, 60, 0, 60, 110, 1'b1);
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        run_phase(1, 1, 33, 33, 40, 1'b0);
        run_phase(0, 0, 33, 33, 20, 1'b0);
        run_phase(200, 256, 33, 33, 100, 1'b0);

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
